// ===== sv/pidcdf_pkg.sv =====
// Package for the dual-form PID controller: register indexes, configuration
// bundle, operand and product records shared by the pipeline stages.
// No dependencies.
package pidcdf_pkg;

	localparam int GainW  = 16;
	localparam int SmpW   = 16;
	localparam int ErrW   = 17;
	localparam int D1W    = 18;
	localparam int D2W    = 19;
	localparam int IntW   = 32;
	localparam int PdW    = 35;
	localparam int IpW    = 48;
	localparam int AccW   = 50;
	localparam int FracW  = 8;
	localparam int ShW    = AccW - FracW;
	localparam int SumW   = ShW + 1;
	localparam int IdxW   = 3;
	localparam int CfgDW  = 32;
	localparam int IlimW  = 31;
	localparam int OlimW  = 15;
	localparam int ThrW   = 16;

	typedef enum logic [IdxW-1:0] {
		REG_INC_MODE  = 3'd0,
		REG_SEP_EN    = 3'd1,
		REG_GAIN_P    = 3'd2,
		REG_GAIN_I    = 3'd3,
		REG_GAIN_D    = 3'd4,
		REG_INT_LIMIT = 3'd5,
		REG_OUT_LIMIT = 3'd6,
		REG_SEP_THR   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic                    incremental;
		logic                    sep_en;
		logic signed [GainW-1:0] gain_p;
		logic signed [GainW-1:0] gain_i;
		logic signed [GainW-1:0] gain_d;
		logic [IlimW-1:0]        int_lim;
		logic [OlimW-1:0]        out_lim;
		logic [ThrW-1:0]         sep_thr;
	} cfg_t;

	typedef struct packed {
		logic signed [D2W-1:0]  p_op;
		logic signed [IntW-1:0] i_op;
		logic signed [D2W-1:0]  d_op;
	} ops_t;

	typedef struct packed {
		logic signed [PdW-1:0] p_prod;
		logic signed [IpW-1:0] i_prod;
		logic signed [PdW-1:0] d_prod;
	} prod_t;

endpackage

// ===== sv/pidcdf_cfg_regs.sv =====
// Configuration register file of the dual-form PID controller.
// Depends on pidcdf_pkg.
module pidcdf_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pidcdf_pkg::IdxW-1:0]   cfg_index,
	input  logic [pidcdf_pkg::CfgDW-1:0]  cfg_data,
	output pidcdf_pkg::cfg_t              cfg
);
	import pidcdf_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.incremental <= 1'b0;
			cfg_q.sep_en      <= 1'b0;
			cfg_q.gain_p      <= '0;
			cfg_q.gain_i      <= '0;
			cfg_q.gain_d      <= '0;
			cfg_q.int_lim     <= '1;
			cfg_q.out_lim     <= '1;
			cfg_q.sep_thr     <= '1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_INC_MODE:  cfg_q.incremental <= cfg_data[0];
				REG_SEP_EN:    cfg_q.sep_en      <= cfg_data[0];
				REG_GAIN_P:    cfg_q.gain_p      <= cfg_data[GainW-1:0];
				REG_GAIN_I:    cfg_q.gain_i      <= cfg_data[GainW-1:0];
				REG_GAIN_D:    cfg_q.gain_d      <= cfg_data[GainW-1:0];
				REG_INT_LIMIT: cfg_q.int_lim     <= cfg_data[IlimW-1:0];
				REG_OUT_LIMIT: cfg_q.out_lim     <= cfg_data[OlimW-1:0];
				REG_SEP_THR:   cfg_q.sep_thr     <= cfg_data[ThrW-1:0];
				default:       cfg_q             <= cfg_q;
			endcase
		end
	end

endmodule

// ===== sv/pidcdf_err_stage.sv =====
// Input register and error stage: error, differences, clamped integral,
// separation test and multiplier operand selection. Holds the error history.
// Depends on pidcdf_pkg.
module pidcdf_err_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pidcdf_pkg::cfg_t              cfg,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [pidcdf_pkg::SmpW-1:0] setpoint,
	input  logic signed [pidcdf_pkg::SmpW-1:0] measurement,
	output logic                          busy,
	output logic                          ops_valid,
	input  logic                          ops_ready,
	output pidcdf_pkg::ops_t              ops
);
	import pidcdf_pkg::*;

	logic signed [SmpW-1:0] sp_s1, ms_s1;
	logic                   v_s1;
	ops_t                   ops_s2;
	logic                   v_s2;
	logic signed [ErrW-1:0] e1_q, e2_q;
	logic signed [IntW-1:0] integ_q;

	logic                   rdy1, rdy2, adv1;
	logic signed [ErrW-1:0] err;
	logic [ErrW-1:0]        mag;
	logic signed [D1W-1:0]  d1;
	logic signed [D2W-1:0]  d2;
	logic signed [IntW:0]   isum, ilim;
	logic signed [IntW-1:0] integ_nxt;
	logic                   use_i;
	ops_t                   ops_nxt;

	assign rdy2      = !v_s2 || ops_ready;
	assign rdy1      = !v_s1 || rdy2;
	assign adv1      = v_s1 && rdy2;
	assign in_stall  = !rdy1;
	assign busy      = v_s1 || v_s2;
	assign ops_valid = v_s2;
	assign ops       = ops_s2;

	always_comb begin
		err = ErrW'(sp_s1) - ErrW'(ms_s1);
		mag = err[ErrW-1] ? ErrW'(-err) : ErrW'(err);
		d1  = D1W'(err) - D1W'(e1_q);
		d2  = D2W'(err) - (D2W'(e1_q) <<< 1) + D2W'(e2_q);
		use_i = !(cfg.sep_en && (mag > ErrW'(cfg.sep_thr)));

		isum = (IntW+1)'(integ_q) + (IntW+1)'(err);
		ilim = $signed({2'b00, cfg.int_lim});
		if (isum > ilim)
			integ_nxt = IntW'(ilim);
		else if (isum < -ilim)
			integ_nxt = IntW'(-ilim);
		else
			integ_nxt = IntW'(isum);

		if (cfg.incremental) begin
			ops_nxt.p_op = D2W'(d1);
			ops_nxt.i_op = IntW'(err);
			ops_nxt.d_op = d2;
		end else begin
			ops_nxt.p_op = D2W'(err);
			ops_nxt.i_op = integ_nxt;
			ops_nxt.d_op = D2W'(d1);
		end
		if (!use_i)
			ops_nxt.i_op = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			e1_q    <= '0;
			e2_q    <= '0;
			integ_q <= '0;
		end else begin
			if (rdy1)
				v_s1 <= in_valid;
			if (rdy2)
				v_s2 <= v_s1;
			if (adv1) begin
				e2_q <= e1_q;
				e1_q <= err;
				if (!cfg.incremental)
					integ_q <= integ_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			sp_s1 <= setpoint;
			ms_s1 <= measurement;
		end
		if (adv1)
			ops_s2 <= ops_nxt;
	end

endmodule

// ===== sv/pidcdf_mac.sv =====
// Multiply and accumulate stages: three gain products, then the sum
// scaled down by the fraction bits with floor rounding.
// Depends on pidcdf_pkg.
module pidcdf_mac (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pidcdf_pkg::cfg_t              cfg,
	input  logic                          ops_valid,
	output logic                          ops_ready,
	input  pidcdf_pkg::ops_t              ops,
	output logic                          busy,
	output logic                          sh_valid,
	input  logic                          sh_ready,
	output logic signed [pidcdf_pkg::ShW-1:0] sh
);
	import pidcdf_pkg::*;

	prod_t                  prod_s3;
	logic                   v_s3;
	logic signed [ShW-1:0]  sh_s4;
	logic                   v_s4;

	logic                   rdy3, rdy4;
	prod_t                  prod_nxt;
	logic signed [AccW-1:0] acc;

	assign rdy4      = !v_s4 || sh_ready;
	assign rdy3      = !v_s3 || rdy4;
	assign ops_ready = rdy3;
	assign sh_valid  = v_s4;
	assign sh        = sh_s4;
	assign busy      = v_s3 || v_s4;

	always_comb begin
		prod_nxt.p_prod = PdW'(cfg.gain_p) * PdW'(ops.p_op);
		prod_nxt.i_prod = IpW'(cfg.gain_i) * IpW'(ops.i_op);
		prod_nxt.d_prod = PdW'(cfg.gain_d) * PdW'(ops.d_op);
		acc = AccW'(prod_s3.p_prod) + AccW'(prod_s3.i_prod) + AccW'(prod_s3.d_prod);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy3)
				v_s3 <= ops_valid;
			if (rdy4)
				v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && ops_valid)
			prod_s3 <= prod_nxt;
		if (rdy4 && v_s3)
			sh_s4 <= acc[AccW-1:FracW];
	end

endmodule

// ===== sv/pidcdf_out_stage.sv =====
// Output stage: adds the held output in incremental form, clamps to the
// output limit and holds the drive register, which is also the held output.
// Depends on pidcdf_pkg.
module pidcdf_out_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pidcdf_pkg::cfg_t              cfg,
	input  logic                          sh_valid,
	output logic                          sh_ready,
	input  logic signed [pidcdf_pkg::ShW-1:0] sh,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [pidcdf_pkg::SmpW-1:0] drive
);
	import pidcdf_pkg::*;

	logic signed [SmpW-1:0] drive_q;
	logic                   out_valid_q;

	logic                   adv;
	logic signed [SumW-1:0] u, lim;
	logic signed [SmpW-1:0] drive_nxt;

	assign sh_ready  = !out_valid_q || !out_stall;
	assign adv       = sh_valid && sh_ready;
	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	always_comb begin
		u   = (cfg.incremental ? SumW'(drive_q) : SumW'(0)) + SumW'(sh);
		lim = $signed({{(SumW-OlimW){1'b0}}, cfg.out_lim});
		if (u > lim)
			drive_nxt = SmpW'(lim);
		else if (u < -lim)
			drive_nxt = SmpW'(-lim);
		else
			drive_nxt = SmpW'(u);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			drive_q     <= '0;
		end else begin
			if (sh_ready)
				out_valid_q <= sh_valid;
			if (adv)
				drive_q <= drive_nxt;
		end
	end

endmodule

// ===== sv/pid_controller_dual_form_unit.sv =====
// Top level of the dual-form (positional / incremental) PID controller
// with integral separation. Depends on pidcdf_pkg and the pidcdf_* stages.
//
//   channel   direction   handshake              payload
//   in        request in  in_valid / in_stall    setpoint, measurement
//   out       request out out_valid / out_stall  drive
//   cfg       write in    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request per cycle while the output is not stalled; the accepting edge loads
// the input register, and the result then passes the error, product, sum and
// output (drive) registers in that order.
// The error/integral stage and the drive register each close their state
// loop in one register. arst_n clears all valids, history, integral and drive;
// configuration returns to its reset values. A stalled output freezes only
// the stages behind it that are full; empty stages keep taking requests.
module pid_controller_dual_form_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pidcdf_pkg::IdxW-1:0]        cfg_index,
	input  logic [pidcdf_pkg::CfgDW-1:0]       cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [pidcdf_pkg::SmpW-1:0] setpoint,
	input  logic signed [pidcdf_pkg::SmpW-1:0] measurement,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [pidcdf_pkg::SmpW-1:0] drive
);
	import pidcdf_pkg::*;

	cfg_t                  cfg;
	ops_t                  ops;
	logic                  ops_valid, ops_ready;
	logic signed [ShW-1:0] sh;
	logic                  sh_valid, sh_ready;
	logic                  err_busy, mac_busy;

	pidcdf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pidcdf_err_stage u_err (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.setpoint    (setpoint),
		.measurement (measurement),
		.busy        (err_busy),
		.ops_valid   (ops_valid),
		.ops_ready   (ops_ready),
		.ops         (ops)
	);

	pidcdf_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.ops_valid (ops_valid),
		.ops_ready (ops_ready),
		.ops       (ops),
		.busy      (mac_busy),
		.sh_valid  (sh_valid),
		.sh_ready  (sh_ready),
		.sh        (sh)
	);

	pidcdf_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.sh_valid  (sh_valid),
		.sh_ready  (sh_ready),
		.sh        (sh),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.drive     (drive)
	);

`ifndef SYNTHESIS
	a_drive_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed({drive[SmpW-1], drive}) <= $signed({2'b00, cfg.out_lim}) &&
			$signed({drive[SmpW-1], drive}) >= -$signed({2'b00, cfg.out_lim})))
		else $error("drive outside output limit");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (err_busy && mac_busy && out_valid))
		else $error("input stalled with an empty stage");

	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(sh_valid))
		else $error("result appeared without a request in the sum stage");

	a_no_loss_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(sh_valid && out_valid && out_stall) |=> sh_valid)
		else $error("sum stage dropped a request while output stalled");
`endif

endmodule

// ===== tb/tb_pid_controller_dual_form_unit.sv =====
// Self-checking testbench for pid_controller_dual_form_unit: directed and random
// setpoint/measurement requests in both control forms, checked against an
// in-file predictor. Depends on pidcdf_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb_pid_controller_dual_form_unit;
	import pidcdf_pkg::*;

	localparam int LIMIT_CYCLES  = 400000;
	localparam int DRAIN_CYCLES  = 20;
	localparam int RAND_PHASES   = 16;
	localparam int PHASE_SAMPLES = 100;

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   cfg_valid   = 1'b0;
	logic                   cfg_ready;
	logic [IdxW-1:0]        cfg_index   = '0;
	logic [CfgDW-1:0]       cfg_data    = '0;
	logic                   in_valid    = 1'b0;
	logic                   in_stall;
	logic signed [SmpW-1:0] setpoint    = '0;
	logic signed [SmpW-1:0] measurement = '0;
	logic                   out_valid;
	logic                   out_stall   = 1'b0;
	logic signed [SmpW-1:0] drive;

	cfg_t                   ctl_cfg;
	longint                 err_1, err_2, integ_acc, drive_held;
	logic [2*SmpW-1:0]      sample_backlog[$];
	logic signed [SmpW-1:0] drive_expected[$];
	int                     idle_pct       = 0;
	int                     stall_pct      = 0;
	int                     errors         = 0;
	int                     samples_sent   = 0;
	int                     drives_checked = 0;
	int                     phases         = 0;
	int                     cycles         = 0;

	pid_controller_dual_form_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.setpoint(setpoint),
		.measurement(measurement),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.drive(drive)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic longint clamp_mag(input longint v, input longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic logic signed [SmpW-1:0] next_drive(input logic signed [SmpW-1:0] sp,
			input logic signed [SmpW-1:0] ms);
		longint e, mag, gp, gi, gd, acc, u;
		logic   keep_i;
		e      = longint'(sp) - longint'(ms);
		mag    = (e < 0) ? -e : e;
		gp     = longint'($signed(ctl_cfg.gain_p));
		gi     = longint'($signed(ctl_cfg.gain_i));
		gd     = longint'($signed(ctl_cfg.gain_d));
		keep_i = !(ctl_cfg.sep_en && mag > longint'(ctl_cfg.sep_thr));
		if (ctl_cfg.incremental) begin
			acc = gp * (e - err_1) + (keep_i ? gi * e : 64'sd0)
				+ gd * (e - 2 * err_1 + err_2);
			u = drive_held + (acc >>> FracW);
		end else begin
			integ_acc = clamp_mag(integ_acc + e, longint'(ctl_cfg.int_lim));
			acc = gp * e + (keep_i ? gi * integ_acc : 64'sd0) + gd * (e - err_1);
			u = acc >>> FracW;
		end
		drive_held = clamp_mag(u, longint'(ctl_cfg.out_lim));
		err_2 = err_1;
		err_1 = e;
		return SmpW'(drive_held);
	endfunction

	function automatic logic [GainW-1:0] pick_gain();
		case ($urandom_range(3))
			0, 1: return GainW'($urandom_range(1024) - 512);
			2: return GainW'($urandom());
			default: begin
				case ($urandom_range(3))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'h0100;
					default: return '0;
				endcase
			end
		endcase
	endfunction

	function automatic int pick_edge();
		case ($urandom_range(4))
			0: return -32768;
			1: return -1;
			2: return 0;
			3: return 1;
			default: return 32767;
		endcase
	endfunction

	task automatic queue_sample(input int sp, input int ms);
		sample_backlog.push_back({SmpW'(sp), SmpW'(ms)});
	endtask

	task automatic settle();
		do @(negedge clk);
		while (sample_backlog.size() != 0 || in_valid || drive_expected.size() != 0);
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [CfgDW-1:0] value);
		logic [CfgDW-1:0] keep, data;
		case (idx) inside
			REG_INC_MODE, REG_SEP_EN: keep = 32'h1;
			REG_GAIN_P, REG_GAIN_I, REG_GAIN_D, REG_SEP_THR: keep = 32'hFFFF;
			REG_INT_LIMIT: keep = 32'h7FFF_FFFF;
			REG_OUT_LIMIT: keep = 32'h7FFF;
			default: keep = '1;
		endcase
		data = (value & keep) | ($urandom_range(1) ? ($urandom() & ~keep) : '0);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_INC_MODE:  ctl_cfg.incremental = data[0];
			REG_SEP_EN:    ctl_cfg.sep_en      = data[0];
			REG_GAIN_P:    ctl_cfg.gain_p      = data[GainW-1:0];
			REG_GAIN_I:    ctl_cfg.gain_i      = data[GainW-1:0];
			REG_GAIN_D:    ctl_cfg.gain_d      = data[GainW-1:0];
			REG_INT_LIMIT: ctl_cfg.int_lim     = data[IlimW-1:0];
			REG_OUT_LIMIT: ctl_cfg.out_lim     = data[OlimW-1:0];
			REG_SEP_THR:   ctl_cfg.sep_thr     = data[ThrW-1:0];
			default: ;
		endcase
	endtask

	task automatic start_phase(input cfg_t c, input int pattern);
		settle();
		case (pattern)
			0: begin
				idle_pct  = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct  = 47;
				stall_pct = 0;
			end
			2: begin
				idle_pct  = 0;
				stall_pct = 47;
			end
			default: begin
				idle_pct  = 31;
				stall_pct = 31;
			end
		endcase
		@(posedge clk);
		cfg_write(REG_INC_MODE, CfgDW'(c.incremental));
		cfg_write(REG_SEP_EN, CfgDW'(c.sep_en));
		cfg_write(REG_GAIN_P, CfgDW'(c.gain_p));
		cfg_write(REG_GAIN_I, CfgDW'(c.gain_i));
		cfg_write(REG_GAIN_D, CfgDW'(c.gain_d));
		cfg_write(REG_INT_LIMIT, CfgDW'(c.int_lim));
		cfg_write(REG_OUT_LIMIT, CfgDW'(c.out_lim));
		cfg_write(REG_SEP_THR, CfgDW'(c.sep_thr));
		cfg_valid <= 1'b0;
		phases++;
	endtask

	// request driver: predict on accept, hold payload while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			setpoint    <= '0;
			measurement <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				drive_expected.push_back(next_drive(setpoint, measurement));
				samples_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (sample_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
					{setpoint, measurement} <= sample_backlog.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (drive_expected.size() == 0) begin
					errors++;
					if (errors <= 40)
						$display("%0t: drive %0d with no request pending", $time, drive);
				end else begin
					if (drive !== drive_expected[0]) begin
						errors++;
						if (errors <= 40)
							$display("%0t: drive mismatch, expected %0d, actual %0d",
								$time, drive_expected[0], drive);
					end
					void'(drive_expected.pop_front());
					drives_checked++;
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin
		cfg_t c;
		int   sp_hold, ms;
		ctl_cfg         = '0;
		ctl_cfg.int_lim = '1;
		ctl_cfg.out_lim = '1;
		ctl_cfg.sep_thr = '1;
		err_1      = 0;
		err_2      = 0;
		integ_acc  = 0;
		drive_held = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// positional, separation at the threshold edge, clamped integral
		c = '0;
		c.sep_en  = 1'b1;
		c.gain_p  = 16'sd256;
		c.gain_i  = 16'sd64;
		c.gain_d  = -16'sd256;
		c.int_lim = 31'd300;
		c.out_lim = 15'h7FFF;
		c.sep_thr = 16'd100;
		start_phase(c, 0);
		queue_sample(100, 0);
		queue_sample(0, 101);
		queue_sample(200, 99);
		queue_sample(-100, 0);
		queue_sample(32767, -32768);
		queue_sample(-32768, 32767);
		queue_sample(0, 0);
		queue_sample(-1, 0);

		// incremental, extreme gains, zero output limit
		c = '0;
		c.incremental = 1'b1;
		c.gain_p      = 16'sh7FFF;
		c.gain_i      = 16'sh8000;
		c.gain_d      = 16'sh7FFF;
		c.int_lim     = '1;
		c.out_lim     = '0;
		c.sep_thr     = '1;
		start_phase(c, 1);
		queue_sample(32767, -32768);
		queue_sample(-32768, 32767);
		queue_sample(5, -3);

		// incremental, zero threshold
		c = '0;
		c.incremental = 1'b1;
		c.sep_en      = 1'b1;
		c.gain_p      = 16'sh8000;
		c.gain_i      = 16'sh7FFF;
		c.gain_d      = 16'sh8000;
		c.int_lim     = '1;
		c.out_lim     = '1;
		c.sep_thr     = '0;
		start_phase(c, 2);
		queue_sample(0, 0);
		queue_sample(1, 0);
		queue_sample(-32768, 32767);
		queue_sample(32767, -32768);
		queue_sample(-5, 7);

		// back to positional with a zero integral limit
		c = '0;
		c.gain_i  = 16'sh7FFF;
		c.int_lim = '0;
		c.out_lim = 15'd1000;
		c.sep_thr = '1;
		start_phase(c, 3);
		queue_sample(300, -300);
		queue_sample(-32768, 32767);
		queue_sample(12, 12);

		// largest threshold never separates
		c = '0;
		c.sep_en  = 1'b1;
		c.gain_p  = 16'sd256;
		c.gain_i  = 16'sd256;
		c.gain_d  = 16'sd256;
		c.int_lim = '1;
		c.out_lim = '1;
		c.sep_thr = '1;
		start_phase(c, 0);
		queue_sample(32767, -32768);
		queue_sample(32767, -32768);
		queue_sample(-32768, 32767);

		sp_hold = 0;
		for (int k = 0; k < RAND_PHASES; k++) begin
			c.incremental = 1'($urandom_range(1));
			c.sep_en      = 1'($urandom_range(1));
			c.gain_p      = pick_gain();
			c.gain_i      = pick_gain();
			c.gain_d      = pick_gain();
			case ($urandom_range(3))
				0: c.int_lim = '0;
				1: c.int_lim = '1;
				2: c.int_lim = IlimW'($urandom_range(4096));
				default: c.int_lim = IlimW'($urandom());
			endcase
			case ($urandom_range(3))
				0: c.out_lim = '0;
				1: c.out_lim = '1;
				2: c.out_lim = OlimW'($urandom_range(2000));
				default: c.out_lim = OlimW'($urandom());
			endcase
			case ($urandom_range(3))
				0: c.sep_thr = '0;
				1: c.sep_thr = '1;
				2: c.sep_thr = ThrW'($urandom_range(600));
				default: c.sep_thr = ThrW'($urandom());
			endcase
			start_phase(c, k % 4);
			for (int n = 0; n < PHASE_SAMPLES; n++) begin
				case ($urandom_range(9))
					6, 7: queue_sample($urandom(), $urandom());
					8, 9: queue_sample(pick_edge(), pick_edge());
					default: begin
						// track a held setpoint with a nearby measurement
						if ($urandom_range(9) == 0)
							sp_hold = int'($urandom_range(65535)) - 32768;
						ms = sp_hold - (int'($urandom_range(1400)) - 700);
						if (ms > 32767)
							ms = 32767;
						if (ms < -32768)
							ms = -32768;
						queue_sample(sp_hold, ms);
					end
				endcase
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d samples over %0d register setups, positional and incremental forms",
			samples_sent, phases);
		$display("%0d drive values checked, %0d mismatches", drives_checked, errors);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
